// ===== src/ptrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrc_pkg
// Shared types, constants and the sine table builder for the pan/tilt/range
// to Cartesian converter.
// ----------------------------------------------------------------------------
package ptrc_pkg;

  localparam int TRIG_FRAC_BITS    = 15;
  localparam int DEGREES_HALF_TURN = 180;
  localparam int FULL_TURN         = 2 * DEGREES_HALF_TURN;
  localparam int QUARTER_TURN      = DEGREES_HALF_TURN / 2;

  // signed trig value: sign plus magnitude up to 1.0
  localparam int TRIG_W    = TRIG_FRAC_BITS + 2;
  localparam int DEG_IDX_W = $clog2(QUARTER_TURN + 1);

  // raw angle span: -511 .. 510 plus a quarter turn for cosine
  localparam int ANG_MIN      = -511;
  localparam int ANG_MAX      = 510 + QUARTER_TURN;
  localparam int ANG_W        = 12;
  localparam int ANG_BIAS     = ((-ANG_MIN + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
  localparam int REDUCE_STEPS = (ANG_MAX + ANG_BIAS) / FULL_TURN;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic [2:0] {
    CFG_CENTER_ANGLE = 3'd0,
    CFG_TILT_OFFSET  = 3'd1,
    CFG_NEAR_LIMIT   = 3'd2,
    CFG_FAR_LIMIT    = 3'd3,
    CFG_MOUNT_HEIGHT = 3'd4,
    CFG_ARM_LENGTH   = 3'd5,
    CFG_BASE_OFFSET  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]         pan_position;
    logic [7:0]         tilt_position;
    logic signed [15:0] range_value;
  } in_payload_t;

  typedef struct packed {
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
  } out_payload_t;

  // load enables of the two registers inside a sine unit
  typedef struct packed {
    logic fold;
    logic look;
  } stage_en_t;

  // Magnitude of sin(d degrees), d in 0..quarter turn, TRIG_FRAC_BITS fraction
  // bits. Q30 Taylor series to x^17, each term truncated, rounded half up.
  // Only called with constant arguments to build the table.
  function automatic logic [TRIG_FRAC_BITS:0] sine_entry(input int unsigned d);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] rnd;
    x    = (64'(d) * PI_Q30) / DEGREES_HALF_TURN;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + signed'(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    rnd = (sum + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    return rnd[TRIG_FRAC_BITS:0];
  endfunction

endpackage

// ===== src/ptrc_sin_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrc_sin_unit
// Two-stage sine: angle reduction and quadrant fold, then table lookup.
// ----------------------------------------------------------------------------
module ptrc_sin_unit (
  input  logic                                clk,
  input  ptrc_pkg::stage_en_t                 en,
  input  logic signed [ptrc_pkg::ANG_W-1:0]   angle_i,
  output logic signed [ptrc_pkg::TRIG_W-1:0]  value_o
);

  localparam int AW = ptrc_pkg::ANG_W;
  localparam int IW = ptrc_pkg::DEG_IDX_W;

  logic [ptrc_pkg::TRIG_FRAC_BITS:0] sin_tab [0:ptrc_pkg::QUARTER_TURN];

  for (genvar g = 0; g <= ptrc_pkg::QUARTER_TURN; g++) begin : g_tab
    assign sin_tab[g] = ptrc_pkg::sine_entry(g);
  end

  logic [AW-1:0]                    red;
  logic [IW-1:0]                    idx_r, idx_nxt;
  logic                             neg_r, neg_nxt;
  logic signed [ptrc_pkg::TRIG_W-1:0] value_r, value_nxt;

  // bias to positive, then bring into one turn
  always_comb begin
    red = unsigned'(angle_i) + AW'(ptrc_pkg::ANG_BIAS);
    for (int k = 0; k < ptrc_pkg::REDUCE_STEPS; k++) begin
      if (red >= AW'(ptrc_pkg::FULL_TURN)) begin
        red = red - AW'(ptrc_pkg::FULL_TURN);
      end
    end
    priority if (red <= AW'(ptrc_pkg::QUARTER_TURN)) begin
      idx_nxt = IW'(red);
      neg_nxt = 1'b0;
    end else if (red <= AW'(ptrc_pkg::DEGREES_HALF_TURN)) begin
      idx_nxt = IW'(AW'(ptrc_pkg::DEGREES_HALF_TURN) - red);
      neg_nxt = 1'b0;
    end else if (red <= AW'(ptrc_pkg::DEGREES_HALF_TURN + ptrc_pkg::QUARTER_TURN)) begin
      idx_nxt = IW'(red - AW'(ptrc_pkg::DEGREES_HALF_TURN));
      neg_nxt = 1'b1;
    end else begin
      idx_nxt = IW'(AW'(ptrc_pkg::FULL_TURN) - red);
      neg_nxt = 1'b1;
    end
  end

  always_comb begin
    value_nxt = signed'({1'b0, sin_tab[idx_r]});
    if (neg_r) begin
      value_nxt = -value_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en.fold) begin
      idx_r <= idx_nxt;
      neg_r <= neg_nxt;
    end
    if (en.look) begin
      value_r <= value_nxt;
    end
  end

  assign value_o = value_r;

endmodule

// ===== src/pan_tilt_range_to_cartesian_core.sv =====
`timescale 1ns / 1ps
// Throughput: one transaction per cycle unless out_ready holds back results;
// the six-stage pipeline (fold, table, multiply, add, multiply, saturate)
// holds one item per stage.
// Items outside the range window or with height not positive give no result.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the
// configuration registers with their defaults.
// ----------------------------------------------------------------------------
// pan_tilt_range_to_cartesian_core
// Converts pan/tilt servo angles and an ultrasonic range into x, y, z.
// ----------------------------------------------------------------------------
module pan_tilt_range_to_cartesian_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ptrc_pkg::in_payload_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ptrc_pkg::out_payload_t out_data,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_wdata
);

  localparam int F       = ptrc_pkg::TRIG_FRAC_BITS;
  localparam int TW      = ptrc_pkg::TRIG_W;
  localparam int AW      = ptrc_pkg::ANG_W;
  localparam int R_W     = 11;                       // arm + range, 1..2045
  localparam int PROD_W  = R_W + 1 + TW;
  localparam int BASE_W  = 16 + F;
  localparam int ZH_W    = ((BASE_W > PROD_W) ? BASE_W : PROD_W) + 1;
  localparam int XY_W    = ZH_W + TW;
  localparam int TWO_F   = 2 * F;

  localparam logic signed [XY_W-1:0] SAT_HI = XY_W'(32767);
  localparam logic signed [XY_W-1:0] SAT_LO = XY_W'(-32768);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]         center_r;
  logic signed [8:0]  tilt_offset_r;
  logic [9:0]         near_r;
  logic [9:0]         far_r;
  logic signed [15:0] mount_height_r;
  logic [9:0]         arm_r;
  logic signed [15:0] base_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r       <= 8'd90;
      tilt_offset_r  <= 9'sd0;
      near_r         <= 10'd2;
      far_r          <= 10'd400;
      mount_height_r <= 16'sd0;
      arm_r          <= 10'd0;
      base_offset_r  <= 16'sd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptrc_pkg::CFG_CENTER_ANGLE: center_r       <= cfg_wdata[7:0];
        ptrc_pkg::CFG_TILT_OFFSET:  tilt_offset_r  <= cfg_wdata[8:0];
        ptrc_pkg::CFG_NEAR_LIMIT:   near_r         <= cfg_wdata[9:0];
        ptrc_pkg::CFG_FAR_LIMIT:    far_r          <= cfg_wdata[9:0];
        ptrc_pkg::CFG_MOUNT_HEIGHT: mount_height_r <= cfg_wdata;
        ptrc_pkg::CFG_ARM_LENGTH:   arm_r          <= cfg_wdata[9:0];
        ptrc_pkg::CFG_BASE_OFFSET:  base_offset_r  <= cfg_wdata;
        default: ;                  // unmapped index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: each stage loads when empty or when its item moves on.
  // The ready chain runs combinationally from out_ready to in_ready, and
  // bubbles are filled even while a result waits.
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt, v5_nxt, out_valid_nxt;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6 = !out_valid_r || out_ready;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ready = rdy1;

  // ---------------------------------------------------------------------------
  // Stage 1: angles, range window, effective radius
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0] pan_ang, elev_ang, tilt_ang;
  logic signed [AW-1:0] ang_sin_p, ang_cos_p, ang_cos_t, ang_cos_e;
  logic signed [16:0]   rng;
  logic                 win_nxt;
  logic [R_W-1:0]       r_nxt;

  always_comb begin
    pan_ang  = $signed(AW'(center_r)) - $signed(AW'(in_data.pan_position));
    elev_ang = $signed(AW'(in_data.tilt_position)) + AW'(tilt_offset_r);
    tilt_ang = elev_ang - $signed(AW'(center_r));
    // cosine is sine a quarter turn ahead
    ang_sin_p = pan_ang;
    ang_cos_p = pan_ang  + $signed(AW'(ptrc_pkg::QUARTER_TURN));
    ang_cos_t = tilt_ang + $signed(AW'(ptrc_pkg::QUARTER_TURN));
    ang_cos_e = elev_ang + $signed(AW'(ptrc_pkg::QUARTER_TURN));
    rng     = 17'(in_data.range_value);
    win_nxt = (rng > $signed({7'b0, near_r})) && (rng < $signed({7'b0, far_r}));
    // inside the window range is 1..1022, so ten bits carry it
    r_nxt   = R_W'(arm_r) + R_W'(in_data.range_value[9:0]);
  end

  ptrc_pkg::stage_en_t    trig_en;
  logic signed [TW-1:0]   sin_p, cos_p, cos_t, cos_e;

  assign trig_en.fold = rdy1;
  assign trig_en.look = rdy2;

  ptrc_sin_unit u_sin_p (.clk(clk), .en(trig_en), .angle_i(ang_sin_p), .value_o(sin_p));
  ptrc_sin_unit u_cos_p (.clk(clk), .en(trig_en), .angle_i(ang_cos_p), .value_o(cos_p));
  ptrc_sin_unit u_cos_t (.clk(clk), .en(trig_en), .angle_i(ang_cos_t), .value_o(cos_t));
  ptrc_sin_unit u_cos_e (.clk(clk), .en(trig_en), .angle_i(ang_cos_e), .value_o(cos_e));

  logic           win1_r, win2_r, win3_r;
  logic [R_W-1:0] r1_r, r2_r;

  // ---------------------------------------------------------------------------
  // Stage 3: radius times cosines
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] pz3_r, ph3_r, pz3_nxt, ph3_nxt;
  logic signed [TW-1:0]     sp3_r, cp3_r, sp4_r, cp4_r;

  assign pz3_nxt = $signed({1'b0, r2_r}) * cos_e;
  assign ph3_nxt = $signed({1'b0, r2_r}) * cos_t;

  // ---------------------------------------------------------------------------
  // Stage 4: height and horizontal reach, height test
  // ---------------------------------------------------------------------------
  logic signed [ZH_W-1:0] z4_r, h4_r, z4_nxt, h4_nxt;
  logic                   keep4_r, keep4_nxt;

  assign z4_nxt    = (ZH_W'(mount_height_r) <<< F) - ZH_W'(pz3_r);
  assign h4_nxt    = (ZH_W'(base_offset_r) <<< F) + ZH_W'(ph3_r);
  assign keep4_nxt = win3_r && (z4_nxt > 0);

  // ---------------------------------------------------------------------------
  // Stage 5: reach times pan sine and cosine
  // ---------------------------------------------------------------------------
  logic signed [XY_W-1:0] x5_r, y5_r, x5_nxt, y5_nxt;
  logic signed [ZH_W-1:0] z5_r;
  logic                   keep5_r;

  assign x5_nxt = h4_r * sp4_r;
  assign y5_nxt = h4_r * cp4_r;

  // ---------------------------------------------------------------------------
  // Stage 6: truncate toward zero, saturate, output register
  // ---------------------------------------------------------------------------
  function automatic logic signed [15:0] sat16(input logic signed [XY_W-1:0] v);
    logic signed [15:0] res;
    priority if (v > SAT_HI) begin
      res = 16'sh7fff;
    end else if (v < SAT_LO) begin
      res = -16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  logic signed [XY_W-1:0] xq, yq, zq;
  ptrc_pkg::out_payload_t out_data_r, out_data_nxt;

  always_comb begin
    // the carry term stays signed so the shift keeps its sign
    xq = (x5_r >>> TWO_F) + $signed(XY_W'(x5_r[XY_W-1] && (|x5_r[TWO_F-1:0])));
    yq = (y5_r >>> TWO_F) + $signed(XY_W'(y5_r[XY_W-1] && (|y5_r[TWO_F-1:0])));
    // z is positive on every kept item, so a plain shift truncates it
    zq = XY_W'(z5_r >>> F);
    out_data_nxt.coord_x = sat16(xq);
    out_data_nxt.coord_y = sat16(yq);
    out_data_nxt.coord_z = sat16(zq);
  end

  // ---------------------------------------------------------------------------
  // Valid bits and payload registers
  // ---------------------------------------------------------------------------
  assign v1_nxt        = rdy1 ? in_valid : v1_r;
  assign v2_nxt        = rdy2 ? v1_r     : v2_r;
  assign v3_nxt        = rdy3 ? v2_r     : v3_r;
  assign v4_nxt        = rdy4 ? v3_r     : v4_r;
  assign v5_nxt        = rdy5 ? v4_r     : v5_r;
  // dropped items leave the pipeline here without a result
  assign out_valid_nxt = rdy6 ? (v5_r && keep5_r) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      v4_r        <= v4_nxt;
      v5_r        <= v5_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      win1_r <= win_nxt;
      r1_r   <= r_nxt;
    end
    if (rdy2) begin
      win2_r <= win1_r;
      r2_r   <= r1_r;
    end
    if (rdy3) begin
      win3_r <= win2_r;
      pz3_r  <= pz3_nxt;
      ph3_r  <= ph3_nxt;
      sp3_r  <= sin_p;
      cp3_r  <= cos_p;
    end
    if (rdy4) begin
      keep4_r <= keep4_nxt;
      z4_r    <= z4_nxt;
      h4_r    <= h4_nxt;
      sp4_r   <= sp3_r;
      cp4_r   <= cp3_r;
    end
    if (rdy5) begin
      keep5_r <= keep4_r;
      z5_r    <= z4_r;
      x5_r    <= x5_nxt;
      y5_r    <= y5_nxt;
    end
    if (rdy6) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_z_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.coord_z >= 0))
    else $error("emitted height is negative");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !rdy2) |=> (v1_r && $stable(r1_r) && $stable(win1_r)))
    else $error("stage 1 item changed while stalled");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v5_r && keep5_r))
    else $error("result appeared without a kept item in stage 5");

  a_radius: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && win1_r) |-> (r1_r != '0))
    else $error("in-window item with zero radius");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: pan/tilt/range to Cartesian converter testbench
// Streams pan/tilt/range triples through the core under a series of register
// settings and checks every emitted point against a cycle-free predictor
// built on a locally computed sine table. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;

  // Settle time for the core's pipeline to empty, with margin to spare.
  localparam int SETTLE_CYCLES = 12;
  // Cycles with no transaction or register write before the run is abandoned.
  localparam int IDLE_LIMIT = 4000;
  localparam int CHUNKS = 10;
  localparam int CHUNK_ITEMS = 95;

  // Angle math of the predictor
  localparam int TURN_DEG = 360;
  localparam int HALF_DEG = 180;
  localparam int QUART_DEG = 90;
  localparam int FRAC = 15;
  localparam longint ONE_Q = 64'sd1 <<< FRAC;
  localparam longint unsigned PI_Q30_VAL = 64'd3373259426;

  // Index with no register behind it
  localparam logic [2:0] CFG_NO_REG = 3'd7;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  ptrc_pkg::in_payload_t  in_data;
  logic                   out_valid;
  logic                   out_ready;
  ptrc_pkg::out_payload_t out_data;
  logic                   cfg_we;
  logic [2:0]             cfg_index;
  logic [15:0]            cfg_wdata;

  pan_tilt_range_to_cartesian_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Clock: 20 ns period
  // --------------------------------------------------------------------------
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a mirror of the register file, updated at the same edge
  // as the core sees the write.
  // --------------------------------------------------------------------------
  logic [7:0]         center_q;
  logic signed [8:0]  tilt_off_q;
  logic [9:0]         near_q;
  logic [9:0]         far_q;
  logic signed [15:0] height_q;
  logic [9:0]         arm_q;
  logic signed [15:0] base_q;

  int sine_lut [0:QUART_DEG];

  ptrc_pkg::in_payload_t  scan_points[$];      // triples waiting to be driven
  ptrc_pkg::out_payload_t expected_points[$];  // points the core still owes

  bit no_idle;          // set for stretches with no idling on either side
  bit in_taken;         // input transaction at the last rising edge
  int send_gap;
  int recv_gap;
  int idle_cycles;
  int items_queued;
  int items_accepted;
  int points_checked;
  int points_dropped;
  int settings_used;
  int error_count;

  // Q15 sine magnitude of d degrees (0..90): Q30 Taylor series to x^17 with
  // each term truncated, then rounded half up.
  function automatic int sine_q15(int d);
    longint unsigned ang;
    longint unsigned sq;
    longint unsigned term;
    longint          acc;
    ang  = (64'(d) * PI_Q30_VAL) / 64'd180;
    sq   = (ang * ang) >> 30;
    term = ang;
    acc  = longint'(ang);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * sq) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return int'((acc + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC));
  endfunction

  // Quadrant folding over any integer angle
  function automatic int sin_deg(int a);
    int m;
    m = a % TURN_DEG;
    if (m < 0) begin
      m = m + TURN_DEG;
    end
    if (m <= QUART_DEG) begin
      return sine_lut[m];
    end
    if (m <= HALF_DEG) begin
      return sine_lut[HALF_DEG - m];
    end
    if (m <= HALF_DEG + QUART_DEG) begin
      return -sine_lut[m - HALF_DEG];
    end
    return -sine_lut[TURN_DEG - m];
  endfunction

  function automatic int cos_deg(int a);
    return sin_deg(a + QUART_DEG);
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Expected point for one triple; returns 0 when the core emits nothing.
  function automatic bit predict_point(ptrc_pkg::in_payload_t it,
                                       output ptrc_pkg::out_payload_t pt);
    int     pan_ang;
    int     tilt_ang;
    int     elev_ang;
    int     rng;
    longint r;
    longint z_q;
    longint h_q;
    pt       = '0;
    rng      = it.range_value;
    pan_ang  = int'(center_q) - int'(it.pan_position);
    elev_ang = int'(it.tilt_position) + int'(tilt_off_q);
    tilt_ang = elev_ang - int'(center_q);
    if (!(rng < int'(far_q) && rng > int'(near_q))) begin
      return 1'b0;
    end
    r   = longint'(arm_q) + longint'(rng);
    // height test is done on the untruncated value
    z_q = longint'(height_q) * ONE_Q - r * cos_deg(elev_ang);
    if (z_q <= 0) begin
      return 1'b0;
    end
    h_q = longint'(base_q) * ONE_Q + r * cos_deg(tilt_ang);
    pt.coord_x = clamp16((h_q * sin_deg(pan_ang)) / (ONE_Q * ONE_Q));
    pt.coord_y = clamp16((h_q * cos_deg(pan_ang)) / (ONE_Q * ONE_Q));
    pt.coord_z = clamp16(z_q / ONE_Q);
    return 1'b1;
  endfunction

  task automatic report_error(string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    error_count++;
  endtask

  // Mostly short gaps, a few long ones
  function automatic int pick_gap(int longest);
    int roll;
    if (no_idle) begin
      return 0;
    end
    roll = $urandom_range(99, 0);
    if (roll < 60) begin
      return 0;
    end
    if (roll < 88) begin
      return $urandom_range(3, 1);
    end
    if (roll < 97) begin
      return $urandom_range(10, 4);
    end
    return $urandom_range(longest, 15);
  endfunction

  // --------------------------------------------------------------------------
  // Rising edge: sample both channels and the register port, keep the
  // predictor in step, check points in order, feed the watchdog.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    ptrc_pkg::out_payload_t pt;
    bit                     busy;
    if (!rst_n) begin
      in_taken    = 1'b0;
      idle_cycles = 0;
      center_q    = 8'd90;
      tilt_off_q  = 9'sd0;
      near_q      = 10'd2;
      far_q       = 10'd400;
      height_q    = 16'sd0;
      arm_q       = 10'd0;
      base_q      = 16'sd0;
    end else begin
      busy     = 1'b0;
      in_taken = in_valid && in_ready;

      if (cfg_we) begin
        busy = 1'b1;
        case (cfg_index)
          ptrc_pkg::CFG_CENTER_ANGLE: center_q   = cfg_wdata[7:0];
          ptrc_pkg::CFG_TILT_OFFSET:  tilt_off_q = cfg_wdata[8:0];
          ptrc_pkg::CFG_NEAR_LIMIT:   near_q     = cfg_wdata[9:0];
          ptrc_pkg::CFG_FAR_LIMIT:    far_q      = cfg_wdata[9:0];
          ptrc_pkg::CFG_MOUNT_HEIGHT: height_q   = cfg_wdata;
          ptrc_pkg::CFG_ARM_LENGTH:   arm_q      = cfg_wdata[9:0];
          ptrc_pkg::CFG_BASE_OFFSET:  base_q     = cfg_wdata;
          default: ;  // no register: write is dropped
        endcase
      end

      // result side: compare against the oldest owed point
      if (out_valid && out_ready) begin
        busy = 1'b1;
        if (expected_points.size() == 0) begin
          report_error($sformatf("unexpected point x=%0d y=%0d z=%0d",
                                 out_data.coord_x, out_data.coord_y, out_data.coord_z));
        end else begin
          pt = expected_points.pop_front();
          if (out_data.coord_x !== pt.coord_x) begin
            report_error($sformatf("coord_x got %0d exp %0d", out_data.coord_x, pt.coord_x));
          end
          if (out_data.coord_y !== pt.coord_y) begin
            report_error($sformatf("coord_y got %0d exp %0d", out_data.coord_y, pt.coord_y));
          end
          if (out_data.coord_z !== pt.coord_z) begin
            report_error($sformatf("coord_z got %0d exp %0d", out_data.coord_z, pt.coord_z));
          end
          points_checked++;
        end
      end

      // input side: predict at acceptance with the settings in force now
      if (in_taken) begin
        busy = 1'b1;
        items_accepted++;
        if (predict_point(in_data, pt)) begin
          expected_points.push_back(pt);
        end else begin
          points_dropped++;
        end
      end

      idle_cycles = busy ? 0 : idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sender: presents the next triple at a falling edge, holds it until taken,
  // then idles for the gap drawn when it was loaded.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (scan_points.size() > 0) begin
      in_data  <= scan_points.pop_front();
      in_valid <= 1'b1;
      send_gap = pick_gap(40);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random back-pressure on the result channel
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      recv_gap = pick_gap(60);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // One register write; bits above the register width carry junk.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val, int width);
    logic [15:0] keep;
    keep = (width >= 16) ? 16'hffff : 16'((32'd1 << width) - 1);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= (16'($urandom) & ~keep) | (val & keep);
  endtask

  task automatic write_all(int center, int offset, int near_v, int far_v,
                           int height, int arm, int base);
    write_reg(ptrc_pkg::CFG_CENTER_ANGLE, 16'(center), 8);
    write_reg(ptrc_pkg::CFG_TILT_OFFSET,  16'(offset), 9);
    write_reg(ptrc_pkg::CFG_NEAR_LIMIT,   16'(near_v), 10);
    write_reg(ptrc_pkg::CFG_FAR_LIMIT,    16'(far_v),  10);
    write_reg(ptrc_pkg::CFG_MOUNT_HEIGHT, 16'(height), 16);
    write_reg(ptrc_pkg::CFG_ARM_LENGTH,   16'(arm),    10);
    write_reg(ptrc_pkg::CFG_BASE_OFFSET,  16'(base),   16);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly usable mounting geometry, sometimes anything the fields hold.
  task automatic random_settings();
    int center;
    int offset;
    int near_v;
    int far_v;
    int height;
    center = ($urandom_range(9, 0) == 0) ? $urandom_range(255, 0) : $urandom_range(180, 0);
    offset = ($urandom_range(9, 0) == 0) ? $urandom_range(511, 0) - 256
                                         : $urandom_range(360, 0) - 180;
    near_v = ($urandom_range(7, 0) == 0) ? $urandom_range(1023, 0) : $urandom_range(40, 0);
    far_v  = ($urandom_range(7, 0) == 0) ? $urandom_range(1023, 0) : $urandom_range(1023, 200);
    height = ($urandom_range(5, 0) == 0) ? $urandom_range(65535, 0) - 32768
                                         : $urandom_range(3000, 0);
    write_all(center, offset, near_v, far_v, height,
              ($urandom_range(3, 0) == 0) ? $urandom_range(1023, 0) : $urandom_range(100, 0),
              ($urandom_range(5, 0) == 0) ? $urandom_range(65535, 0) - 32768
                                          : $urandom_range(400, 0) - 200);
    if ($urandom_range(3, 0) == 0) begin
      write_reg(CFG_NO_REG, 16'($urandom), 16);
      @(negedge clk);
      cfg_we <= 1'b0;
    end
  endtask

  task automatic add_item(int pan, int tilt, int rng);
    ptrc_pkg::in_payload_t it;
    it.pan_position  = 8'(pan);
    it.tilt_position = 8'(tilt);
    it.range_value   = 16'(rng);
    scan_points.push_back(it);
    items_queued++;
  endtask

  // Ranges mostly inside the window so points come out; the rest are edge
  // values and raw sensor noise.
  task automatic add_random_item();
    int pan;
    int tilt;
    int rng;
    int roll;
    pan  = ($urandom_range(7, 0) == 0) ? $urandom_range(255, 0) : $urandom_range(180, 0);
    tilt = ($urandom_range(7, 0) == 0) ? $urandom_range(255, 0) : $urandom_range(180, 0);
    roll = $urandom_range(99, 0);
    if (roll < 70 && int'(far_q) > int'(near_q) + 1) begin
      rng = $urandom_range(int'(far_q) - 1, int'(near_q) + 1);
    end else if (roll < 85) begin
      case ($urandom_range(3, 0))
        0: rng = int'(near_q);
        1: rng = int'(near_q) + 1;
        2: rng = int'(far_q) - 1;
        default: rng = int'(far_q);
      endcase
    end else begin
      rng = $urandom_range(65535, 0) - 32768;
    end
    add_item(pan, tilt, rng);
  endtask

  // Waits until every queued triple is taken and every point has arrived,
  // then gives the pipeline time to empty of triples that gave none.
  task automatic wait_drained();
    while (items_accepted != items_queued || expected_points.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin : watchdog
    @(posedge rst_n);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
    end
    $display("[%0t] ERROR: no transaction for %0d cycles, %0d points owed",
             $realtime, IDLE_LIMIT, expected_points.size());
    $display("** pan_tilt_range_to_cartesian_core: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = ptrc_pkg::CFG_CENTER_ANGLE;
    cfg_wdata = '0;
    no_idle   = 1'b0;
    send_gap  = 0;
    recv_gap  = 0;
    items_queued   = 0;
    items_accepted = 0;
    points_checked = 0;
    points_dropped = 0;
    settings_used  = 0;
    error_count    = 0;
    for (int d = 0; d <= QUART_DEG; d++) begin
      sine_lut[d] = sine_q15(d);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: center 90, no offset, window (2,400), zero geometry.
    // Height just above ground truncates to zero.
    add_item(90, 91, 3);
    add_item(0, 180, 399);
    add_item(180, 135, 100);
    // angles past a half turn
    add_item(255, 255, 50);
    // below ground: nothing
    add_item(45, 0, 100);
    // level sensor: height exactly zero, nothing
    add_item(0, 90, 200);
    // window edges and sensor extremes: nothing
    add_item(90, 180, 2);
    add_item(90, 180, 400);
    add_item(90, 180, -32768);
    add_item(90, 180, 32767);
    wait_drained();

    // Extremes of every field; some coordinates saturate high.
    write_all(255, -256, 0, 1023, 32767, 1023, 32767);
    add_item(0, 0, 1);
    add_item(255, 255, 1022);
    add_item(128, 76, 500);
    add_item(0, 255, 1);
    add_item(255, 0, 1022);
    wait_drained();

    // Empty window (far not above near) plus an unmapped register write.
    write_all(0, 255, 0, 0, -32768, 0, -32768);
    write_reg(CFG_NO_REG, 16'hffff, 16);
    @(negedge clk);
    cfg_we <= 1'b0;
    add_item(0, 0, 0);
    add_item(255, 255, 1);
    add_item(10, 20, -1);
    wait_drained();

    // Signed extremes the other way; negative saturation on x/y.
    write_all(180, -180, 0, 1023, 32767, 0, -32768);
    add_item(0, 0, 1022);
    add_item(180, 180, 1022);
    add_item(90, 90, 511);
    add_item(0, 180, 1);
    wait_drained();

    // Random part: new settings before most chunks, two chunks at full rate.
    for (int c = 0; c < CHUNKS; c++) begin
      if (c % 3 != 2) begin
        random_settings();
      end
      no_idle = (c == 3 || c == 7);
      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        add_random_item();
      end
      wait_drained();
    end
    no_idle = 1'b0;

    $display("Converted %0d triples under %0d register settings: %0d points checked,",
             items_accepted, settings_used, points_checked);
    $display("%0d triples out of window or below ground, %0d errors",
             points_dropped, error_count);
    if (error_count == 0) begin
      $display("** pan_tilt_range_to_cartesian_core: PASSED **");
    end else begin
      $display("** pan_tilt_range_to_cartesian_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ptrc_pkg.sv
src/ptrc_sin_unit.sv
src/pan_tilt_range_to_cartesian_core.sv
test/tb.sv
